FILE: rtl/phts_pkg.sv
// Shared types and constants for the PES header timestamp scanner.
package phts_pkg;

  // Stream kind codes
  localparam logic [1:0] KIND_VIDEO   = 2'd0;
  localparam logic [1:0] KIND_AUDIO   = 2'd1;
  localparam logic [1:0] KIND_PRIVATE = 2'd2;

  // Stream id values and start code
  localparam logic [3:0]  VIDEO_ID_HI   = 4'hE;
  localparam logic [2:0]  AUDIO_ID_HI   = 3'b110;
  localparam logic [7:0]  PRIVATE_ONE   = 8'hBD;
  localparam logic [23:0] START_PREFIX  = 24'h000001;
  localparam logic [7:0]  HDR_LEN_LIMIT = 8'd5;

  // Timestamp widths
  localparam int TS_W   = 33;
  localparam int SEC_W  = 17;
  localparam int FRAC_W = 14;

  // 90 kHz clock: ticks per second and per ten-thousandth
  localparam int TICKS_PER_SEC  = 27000000 / 300;
  localparam int TICKS_PER_FRAC = TICKS_PER_SEC / 10000;

  // Seconds split: drop 4 low bits, then divide by the odd part
  localparam int SEC_SHIFT   = 4;
  localparam int SEC_DIV     = TICKS_PER_SEC / (1 << SEC_SHIFT);
  localparam int SEC_DIV_W   = 13;
  localparam int HI_W        = TS_W - SEC_SHIFT;
  localparam int RECIP_SHIFT = 42;
  localparam int RECIP_W     = 30;
  localparam logic [RECIP_W-1:0] SEC_RECIP =
    RECIP_W'((64'd1 << RECIP_SHIFT) / SEC_DIV);
  localparam int PROD1_W = HI_W + RECIP_W;
  localparam int REM_W   = SEC_DIV_W + SEC_SHIFT;

  // Fraction: exact divide of the remainder by a multiply-and-shift
  localparam int FRAC_SHIFT = 21;
  localparam int FRAC_MUL_W = 18;
  localparam logic [FRAC_MUL_W-1:0] FRAC_MUL =
    FRAC_MUL_W'(((64'd1 << FRAC_SHIFT) + TICKS_PER_FRAC - 1) / TICKS_PER_FRAC);
  localparam int PROD4_W = REM_W + FRAC_MUL_W;

  // One parsed header
  typedef struct packed {
    logic [7:0]      stream_id;
    logic [1:0]      stream_kind;
    logic [4:0]      stream_number;
    logic [15:0]     packet_length;
    logic [7:0]      header_length;
    logic [TS_W-1:0] pts;
    logic            has_dts;
    logic [TS_W-1:0] dts;
  } phts_rec_t;

endpackage

FILE: rtl/phts_tick_split.sv
// Pipelined split of a 90 kHz timestamp into seconds and ten-thousandths.
module phts_tick_split (
  input  logic                           clk,
  input  logic [phts_pkg::TS_W-1:0]      ticks,
  output logic [phts_pkg::SEC_W-1:0]     seconds,
  output logic [phts_pkg::FRAC_W-1:0]   fraction
);

  logic [phts_pkg::PROD1_W-1:0]   prod1_r;
  logic [phts_pkg::HI_W-1:0]      hi1_r;
  logic [phts_pkg::SEC_SHIFT-1:0] lo1_r;

  logic [phts_pkg::SEC_W-1:0]     q0;
  logic [phts_pkg::SEC_W-1:0]     q2_r;
  logic [phts_pkg::HI_W-1:0]      qd2_r;
  logic [phts_pkg::HI_W-1:0]      hi2_r;
  logic [phts_pkg::SEC_SHIFT-1:0] lo2_r;

  logic [phts_pkg::SEC_DIV_W:0]   rem0;
  logic [phts_pkg::SEC_W-1:0]     q3_nxt;
  logic [phts_pkg::SEC_DIV_W-1:0] rem3;
  logic [phts_pkg::SEC_W-1:0]     q3_r;
  logic [phts_pkg::REM_W-1:0]     rem3_r;

  logic [phts_pkg::PROD4_W-1:0]   prod4_r;
  logic [phts_pkg::SEC_W-1:0]     q4_r;

  // Estimate quotient, possibly one low; correct against the remainder
  always_comb begin
    q0   = prod1_r[phts_pkg::PROD1_W-1 -: phts_pkg::SEC_W];
    rem0 = (phts_pkg::SEC_DIV_W + 1)'(hi2_r - qd2_r);
    if (rem0 >= (phts_pkg::SEC_DIV_W + 1)'(phts_pkg::SEC_DIV)) begin
      q3_nxt = q2_r + phts_pkg::SEC_W'(1);
      rem3   = phts_pkg::SEC_DIV_W'(rem0 - (phts_pkg::SEC_DIV_W + 1)'(phts_pkg::SEC_DIV));
    end else begin
      q3_nxt = q2_r;
      rem3   = phts_pkg::SEC_DIV_W'(rem0);
    end
  end

  // Advance the four stages every cycle
  always_ff @(posedge clk) begin
    prod1_r <= phts_pkg::PROD1_W'(ticks[phts_pkg::TS_W-1:phts_pkg::SEC_SHIFT]) *
               phts_pkg::PROD1_W'(phts_pkg::SEC_RECIP);
    hi1_r   <= ticks[phts_pkg::TS_W-1:phts_pkg::SEC_SHIFT];
    lo1_r   <= ticks[phts_pkg::SEC_SHIFT-1:0];

    q2_r    <= q0;
    qd2_r   <= phts_pkg::HI_W'(phts_pkg::HI_W'(q0) *
                               phts_pkg::HI_W'(phts_pkg::SEC_DIV));
    hi2_r   <= hi1_r;
    lo2_r   <= lo1_r;

    q3_r    <= q3_nxt;
    rem3_r  <= {rem3, lo2_r};

    q4_r    <= q3_r;
    prod4_r <= phts_pkg::PROD4_W'(rem3_r) * phts_pkg::PROD4_W'(phts_pkg::FRAC_MUL);
  end

  assign seconds  = q4_r;
  assign fraction = prod4_r[phts_pkg::FRAC_SHIFT +: phts_pkg::FRAC_W];

endmodule

FILE: rtl/phts_parser.sv
// Byte parser: start code search, header field capture and record build.
module phts_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_valid,
  input  logic [7:0]          data_byte,
  input  logic                busy,
  output logic                byte_ready,
  output phts_pkg::phts_rec_t rec,
  output logic                rec_load
);

  typedef enum logic [3:0] {
    PH_SCAN, PH_LEN_HI, PH_LEN_LO, PH_FLAGS_A, PH_FLAGS_B, PH_HDR_LEN,
    PH_PTS_0, PH_PTS_1, PH_PTS_2, PH_PTS_3, PH_PTS_4,
    PH_DTS_0, PH_DTS_1, PH_DTS_2, PH_DTS_3, PH_DTS_4
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [23:0]         window_r, window_nxt;
  logic [1:0]          fill_r, fill_nxt;
  logic [7:0]          sid_r, sid_nxt;
  logic [15:0]         len_r, len_nxt;
  logic [7:0]          hlen_r, hlen_nxt;
  logic [31:0]         stamp_r, stamp_nxt;
  logic [phts_pkg::TS_W-1:0] pts_r, pts_nxt;
  phts_pkg::phts_rec_t rec_r, rec_nxt;
  logic                rec_load_r, rec_load_nxt;
  logic [phts_pkg::TS_W-1:0] stamp_dec;
  logic                byte_ok;

  function automatic logic is_video(input logic [7:0] id);
    is_video = (id[7:4] == phts_pkg::VIDEO_ID_HI);
  endfunction

  function automatic logic is_audio(input logic [7:0] id);
    is_audio = (id[7:5] == phts_pkg::AUDIO_ID_HI);
  endfunction

  // Build a record from the held header fields
  function automatic phts_pkg::phts_rec_t make_rec(
    input logic [7:0] id, input logic [15:0] len, input logic [7:0] hlen,
    input logic [phts_pkg::TS_W-1:0] pts, input logic with_dts,
    input logic [phts_pkg::TS_W-1:0] dts);
    phts_pkg::phts_rec_t r;
    r.stream_id     = id;
    r.packet_length = len;
    r.header_length = hlen;
    r.pts           = pts;
    r.has_dts       = with_dts;
    r.dts           = with_dts ? dts : '0;
    if (is_video(id)) begin
      r.stream_kind   = phts_pkg::KIND_VIDEO;
      r.stream_number = {1'b0, id[3:0]};
    end else if (is_audio(id)) begin
      r.stream_kind   = phts_pkg::KIND_AUDIO;
      r.stream_number = id[4:0];
    end else begin
      r.stream_kind   = phts_pkg::KIND_PRIVATE;
      r.stream_number = '0;
    end
    make_rec = r;
  endfunction

  // Hold off the last byte of each timestamp while the previous result is in flight
  assign byte_ready = !(((phase_r == PH_PTS_4) || (phase_r == PH_DTS_4)) && busy);
  assign byte_ok    = byte_valid && byte_ready;

  // Drop marker bits: 3 + 15 + 15 payload bits
  assign stamp_dec = {stamp_r[27:25], stamp_r[23:9], stamp_r[7:0], data_byte[7:1]};

  always_comb begin
    phase_nxt    = phase_r;
    window_nxt   = window_r;
    fill_nxt     = fill_r;
    sid_nxt      = sid_r;
    len_nxt      = len_r;
    hlen_nxt     = hlen_r;
    stamp_nxt    = stamp_r;
    pts_nxt      = pts_r;
    rec_nxt      = rec_r;
    rec_load_nxt = 1'b0;
    if (byte_ok) begin
      unique case (phase_r)
        PH_SCAN: begin
          if (fill_r != 2'd3) begin
            window_nxt = {window_r[15:0], data_byte};
            fill_nxt   = fill_r + 2'd1;
          end else if ((window_r == phts_pkg::START_PREFIX) &&
                       (is_video(data_byte) || is_audio(data_byte) ||
                        (data_byte == phts_pkg::PRIVATE_ONE))) begin
            sid_nxt    = data_byte;
            window_nxt = '0;
            fill_nxt   = '0;
            phase_nxt  = PH_LEN_HI;
          end else begin
            window_nxt = {window_r[15:0], data_byte};
          end
        end
        PH_LEN_HI: begin
          len_nxt   = {data_byte, 8'h00};
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_nxt   = {len_r[15:8], data_byte};
          phase_nxt = PH_FLAGS_A;
        end
        PH_FLAGS_A: phase_nxt = PH_FLAGS_B;
        PH_FLAGS_B: phase_nxt = PH_HDR_LEN;
        PH_HDR_LEN: begin
          hlen_nxt  = data_byte;
          phase_nxt = PH_PTS_0;
        end
        PH_PTS_4: begin
          if (is_video(sid_r) && (hlen_r > phts_pkg::HDR_LEN_LIMIT)) begin
            pts_nxt   = stamp_dec;
            phase_nxt = PH_DTS_0;
          end else begin
            rec_nxt      = make_rec(sid_r, len_r, hlen_r, stamp_dec, 1'b0, '0);
            rec_load_nxt = 1'b1;
            phase_nxt    = PH_SCAN;
          end
        end
        PH_DTS_4: begin
          rec_nxt      = make_rec(sid_r, len_r, hlen_r, pts_r, 1'b1, stamp_dec);
          rec_load_nxt = 1'b1;
          phase_nxt    = PH_SCAN;
        end
        default: begin
          // Timestamp bytes before the last one
          stamp_nxt = {stamp_r[23:0], data_byte};
          phase_nxt = phase_t'(phase_r + 4'd1);
        end
      endcase
    end
  end

  // Hold state and the registered record
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SCAN;
      window_r   <= '0;
      fill_r     <= '0;
      rec_load_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      window_r   <= window_nxt;
      fill_r     <= fill_nxt;
      rec_load_r <= rec_load_nxt;
    end
    sid_r   <= sid_nxt;
    len_r   <= len_nxt;
    hlen_r  <= hlen_nxt;
    stamp_r <= stamp_nxt;
    pts_r   <= pts_nxt;
    rec_r   <= rec_nxt;
  end

  assign rec      = rec_r;
  assign rec_load = rec_load_r;

endmodule

FILE: rtl/pes_header_timestamp_scanner.sv
// Top level: byte parser, timestamp split pipelines and result register.
// Throughput: one byte accepted per cycle; only the last byte of a timestamp
// waits, and only while the previous result is still in flight or unread.
// A header's record is registered in the parser, then tracked by vld_r through the split.
// The seconds/fraction split is a 4-stage multiply-by-reciprocal pipeline.
// Reset (rst_n low, synchronous) empties the window, returns to start-code
// search and drops any result in flight.
module pes_header_timestamp_scanner (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_data_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_stream_id,
  output logic [1:0]                    out_stream_kind,
  output logic [4:0]                    out_stream_number,
  output logic [15:0]                   out_packet_length,
  output logic [7:0]                    out_header_length,
  output logic [phts_pkg::TS_W-1:0]     out_pts,
  output logic [phts_pkg::SEC_W-1:0]    out_pts_seconds,
  output logic [phts_pkg::FRAC_W-1:0]  out_pts_fraction,
  output logic                          out_has_dts,
  output logic [phts_pkg::TS_W-1:0]     out_dts,
  output logic [phts_pkg::SEC_W-1:0]    out_dts_seconds,
  output logic [phts_pkg::FRAC_W-1:0]  out_dts_fraction
);

  phts_pkg::phts_rec_t rec;
  logic                rec_load;
  logic                busy;
  logic [2:0]          vld_r;
  logic                out_valid_r;

  phts_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_valid),
    .data_byte  (in_data_byte),
    .busy       (busy),
    .byte_ready (in_ready),
    .rec        (rec),
    .rec_load   (rec_load)
  );

  phts_tick_split u_pts_split (
    .clk      (clk),
    .ticks    (rec.pts),
    .seconds  (out_pts_seconds),
    .fraction (out_pts_fraction)
  );

  phts_tick_split u_dts_split (
    .clk      (clk),
    .ticks    (rec.dts),
    .seconds  (out_dts_seconds),
    .fraction (out_dts_fraction)
  );

  // A result is in flight from record load until the item is taken
  assign busy = rec_load || (vld_r != 3'b000) || out_valid_r;

  // Track the record through the split pipeline, then hold the item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r <= {vld_r[1:0], rec_load};
      if (vld_r[2]) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_stream_id     = rec.stream_id;
  assign out_stream_kind   = rec.stream_kind;
  assign out_stream_number = rec.stream_number;
  assign out_packet_length = rec.packet_length;
  assign out_header_length = rec.header_length;
  assign out_pts           = rec.pts;
  assign out_has_dts       = rec.has_dts;
  assign out_dts           = rec.dts;

endmodule

FILE: tb/phts_checker.sv
// Checker for the PES header scanner: tracks accepted bytes, predicts header results, compares.
module phts_checker
  import phts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [7:0]        out_stream_id,
  input  logic [1:0]        out_stream_kind,
  input  logic [4:0]        out_stream_number,
  input  logic [15:0]       out_packet_length,
  input  logic [7:0]        out_header_length,
  input  logic [TS_W-1:0]   out_pts,
  input  logic [SEC_W-1:0]  out_pts_seconds,
  input  logic [FRAC_W-1:0] out_pts_fraction,
  input  logic              out_has_dts,
  input  logic [TS_W-1:0]   out_dts,
  input  logic [SEC_W-1:0]  out_dts_seconds,
  input  logic [FRAC_W-1:0] out_dts_fraction,
  output int                error_count,
  output int                headers_due
);
  timeunit 1ns;
  timeprecision 1ps;

  // 90 kHz clock
  localparam longint unsigned TICKS_PER_SECOND       = 90000;
  localparam longint unsigned TICKS_PER_TEN_THOUSAND = 9;

  // Position within a PES header
  typedef enum logic [3:0] {
    PH_SCAN, PH_LEN_HI, PH_LEN_LO, PH_FLAGS_A, PH_FLAGS_B, PH_HDR_LEN,
    PH_PTS_0, PH_PTS_1, PH_PTS_2, PH_PTS_3, PH_PTS_4,
    PH_DTS_0, PH_DTS_1, PH_DTS_2, PH_DTS_3, PH_DTS_4
  } parse_phase_t;

  typedef struct {
    logic [7:0]        stream_id;
    logic [1:0]        stream_kind;
    logic [4:0]        stream_number;
    logic [15:0]       packet_length;
    logic [7:0]        header_length;
    logic [TS_W-1:0]   pts;
    logic [SEC_W-1:0]  pts_seconds;
    logic [FRAC_W-1:0] pts_fraction;
    logic              has_dts;
    logic [TS_W-1:0]   dts;
    logic [SEC_W-1:0]  dts_seconds;
    logic [FRAC_W-1:0] dts_fraction;
  } pes_header_t;

  pes_header_t     parsed_headers[$];
  logic [23:0]     win_bytes;
  logic [1:0]      win_fill;
  parse_phase_t    phase;
  logic [7:0]      hold_id;
  logic [15:0]     hold_len;
  logic [7:0]      hold_hdr_len;
  logic [31:0]     stamp_acc;
  logic [TS_W-1:0] hold_pts;
  int              mismatch_total;

  // Drop the marker bits: 3 + 15 + 15 payload bits
  function automatic logic [TS_W-1:0] unpack_stamp(input logic [31:0] first4,
                                                   input logic [7:0] last);
    return {first4[27:25], first4[23:9], first4[7:0], last[7:1]};
  endfunction

  function automatic logic [SEC_W-1:0] stamp_seconds(input logic [TS_W-1:0] ts);
    longint unsigned t;
    t = ts;
    return SEC_W'(t / TICKS_PER_SECOND);
  endfunction

  function automatic logic [FRAC_W-1:0] stamp_fraction(input logic [TS_W-1:0] ts);
    longint unsigned t;
    t = ts;
    return FRAC_W'((t % TICKS_PER_SECOND) / TICKS_PER_TEN_THOUSAND);
  endfunction

  function automatic logic is_video(input logic [7:0] id);
    return id[7:4] == VIDEO_ID_HI;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("[%0t] mismatch %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    mismatch_total++;
  endtask

  // Build the result for the header just completed and queue it
  task automatic close_header(input logic with_dts, input logic [TS_W-1:0] dts_raw);
    pes_header_t h;
    h.stream_id = hold_id;
    if (is_video(hold_id)) begin
      h.stream_kind   = KIND_VIDEO;
      h.stream_number = {1'b0, hold_id[3:0]};
    end else if (hold_id[7:5] == AUDIO_ID_HI) begin
      h.stream_kind   = KIND_AUDIO;
      h.stream_number = hold_id[4:0];
    end else begin
      h.stream_kind   = KIND_PRIVATE;
      h.stream_number = '0;
    end
    h.packet_length = hold_len;
    h.header_length = hold_hdr_len;
    h.pts           = hold_pts;
    h.pts_seconds   = stamp_seconds(hold_pts);
    h.pts_fraction  = stamp_fraction(hold_pts);
    h.has_dts       = with_dts;
    h.dts           = with_dts ? dts_raw : '0;
    h.dts_seconds   = stamp_seconds(h.dts);
    h.dts_fraction  = stamp_fraction(h.dts);
    parsed_headers.push_back(h);
  endtask

  // Advance the scanner by one accepted byte
  task automatic parse_byte(input logic [7:0] b);
    case (phase)
      PH_SCAN: begin
        if (win_fill != 2'd3) begin
          win_bytes = {win_bytes[15:0], b};
          win_fill  = win_fill + 2'd1;
        end else if (win_bytes == START_PREFIX &&
                     (is_video(b) || b[7:5] == AUDIO_ID_HI || b == PRIVATE_ONE)) begin
          hold_id   = b;
          win_bytes = '0;
          win_fill  = '0;
          phase     = PH_LEN_HI;
        end else begin
          win_bytes = {win_bytes[15:0], b};
        end
      end
      PH_PTS_4: begin
        hold_pts = unpack_stamp(stamp_acc, b);
        if (is_video(hold_id) && hold_hdr_len > HDR_LEN_LIMIT) begin
          phase = PH_DTS_0;
        end else begin
          close_header(1'b0, '0);
          phase = PH_SCAN;
        end
      end
      PH_DTS_4: begin
        close_header(1'b1, unpack_stamp(stamp_acc, b));
        phase = PH_SCAN;
      end
      default: begin
        // length, header length and timestamp bytes are held; flag bytes are skipped
        if (phase == PH_LEN_HI) hold_len = {b, 8'h00};
        else if (phase == PH_LEN_LO) hold_len[7:0] = b;
        else if (phase == PH_HDR_LEN) hold_hdr_len = b;
        else if (phase >= PH_PTS_0) stamp_acc = {stamp_acc[23:0], b};
        phase = parse_phase_t'(phase + 4'd1);
      end
    endcase
  endtask

  // Predict on accepted bytes, compare each accepted result with the oldest header
  always @(posedge clk) begin
    pes_header_t want;
    if (!rst_n) begin
      win_bytes    = '0;
      win_fill     = '0;
      phase        = PH_SCAN;
      hold_id      = '0;
      hold_len     = '0;
      hold_hdr_len = '0;
      stamp_acc    = '0;
      hold_pts     = '0;
      parsed_headers.delete();
    end else begin
      if (in_valid && in_ready) parse_byte(in_data_byte);
      if (out_valid && out_ready) begin
        if (parsed_headers.size() == 0) begin
          report_mismatch("result with no header pending, stream_id", '0, out_stream_id);
        end else begin
          want = parsed_headers.pop_front();
          if (out_stream_id !== want.stream_id)
            report_mismatch("stream_id", want.stream_id, out_stream_id);
          if (out_stream_kind !== want.stream_kind)
            report_mismatch("stream_kind", want.stream_kind, out_stream_kind);
          if (out_stream_number !== want.stream_number)
            report_mismatch("stream_number", want.stream_number, out_stream_number);
          if (out_packet_length !== want.packet_length)
            report_mismatch("packet_length", want.packet_length, out_packet_length);
          if (out_header_length !== want.header_length)
            report_mismatch("header_length", want.header_length, out_header_length);
          if (out_pts !== want.pts)
            report_mismatch("pts", want.pts, out_pts);
          if (out_pts_seconds !== want.pts_seconds)
            report_mismatch("pts_seconds", want.pts_seconds, out_pts_seconds);
          if (out_pts_fraction !== want.pts_fraction)
            report_mismatch("pts_fraction", want.pts_fraction, out_pts_fraction);
          if (out_has_dts !== want.has_dts)
            report_mismatch("has_dts", want.has_dts, out_has_dts);
          if (out_dts !== want.dts)
            report_mismatch("dts", want.dts, out_dts);
          if (out_dts_seconds !== want.dts_seconds)
            report_mismatch("dts_seconds", want.dts_seconds, out_dts_seconds);
          if (out_dts_fraction !== want.dts_fraction)
            report_mismatch("dts_fraction", want.dts_fraction, out_dts_fraction);
        end
      end
    end
    error_count <= mismatch_total;
    headers_due <= parsed_headers.size();
  end

endmodule

FILE: tb/tb_top.sv
// Top of the PES header scanner testbench: clock, reset, byte stimulus, result sink, verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import phts_pkg::*;

  localparam logic [TS_W-1:0] STAMP_MAX = '1;
  localparam int              RANDOM_BYTES = 1050;
  localparam int              QUIET_TAIL = 100;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        in_data_byte;
  logic              out_valid;
  logic              out_ready;
  logic [7:0]        out_stream_id;
  logic [1:0]        out_stream_kind;
  logic [4:0]        out_stream_number;
  logic [15:0]       out_packet_length;
  logic [7:0]        out_header_length;
  logic [TS_W-1:0]   out_pts;
  logic [SEC_W-1:0]  out_pts_seconds;
  logic [FRAC_W-1:0] out_pts_fraction;
  logic              out_has_dts;
  logic [TS_W-1:0]   out_dts;
  logic [SEC_W-1:0]  out_dts_seconds;
  logic [FRAC_W-1:0] out_dts_fraction;
  int                error_count;
  int                headers_due;

  bit src_idle_on;
  bit sink_stall_on;
  int bytes_sent;

  pes_header_timestamp_scanner dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_stream_id     (out_stream_id),
    .out_stream_kind   (out_stream_kind),
    .out_stream_number (out_stream_number),
    .out_packet_length (out_packet_length),
    .out_header_length (out_header_length),
    .out_pts           (out_pts),
    .out_pts_seconds   (out_pts_seconds),
    .out_pts_fraction  (out_pts_fraction),
    .out_has_dts       (out_has_dts),
    .out_dts           (out_dts),
    .out_dts_seconds   (out_dts_seconds),
    .out_dts_fraction  (out_dts_fraction)
  );

  phts_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_stream_id     (out_stream_id),
    .out_stream_kind   (out_stream_kind),
    .out_stream_number (out_stream_number),
    .out_packet_length (out_packet_length),
    .out_header_length (out_header_length),
    .out_pts           (out_pts),
    .out_pts_seconds   (out_pts_seconds),
    .out_pts_fraction  (out_pts_fraction),
    .out_has_dts       (out_has_dts),
    .out_dts           (out_dts),
    .out_dts_seconds   (out_dts_seconds),
    .out_dts_fraction  (out_dts_fraction),
    .error_count       (error_count),
    .headers_due       (headers_due)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Hold one byte until accepted, then maybe idle for a burst
  task automatic send_byte(input logic [7:0] b);
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (src_idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Five timestamp bytes with random marker bits
  task automatic send_stamp(input logic [TS_W-1:0] ts);
    logic [7:0] mark;
    mark = 8'($urandom);
    send_byte({mark[3:0], ts[32:30], mark[4]});
    send_byte(ts[29:22]);
    send_byte({ts[21:15], mark[5]});
    send_byte(ts[14:7]);
    send_byte({ts[6:0], mark[6]});
  endtask

  // Start code, id, length, flags, header length, PTS and the DTS where video needs one
  task automatic send_header(input logic [7:0] id, input logic [15:0] plen,
                             input logic [7:0] hlen, input logic [TS_W-1:0] pts,
                             input logic [TS_W-1:0] dts);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(id);
    send_byte(plen[15:8]);
    send_byte(plen[7:0]);
    send_byte(8'($urandom));
    send_byte(8'($urandom));
    send_byte(hlen);
    send_stamp(pts);
    if (id[7:4] == VIDEO_ID_HI && hlen > HDR_LEN_LIMIT) send_stamp(dts);
  endtask

  function automatic logic [TS_W-1:0] random_stamp();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return STAMP_MAX;
      default: return {1'($urandom_range(0, 1)), 32'($urandom)};
    endcase
  endfunction

  function automatic logic [7:0] random_id();
    case ($urandom_range(0, 2))
      0:       return {VIDEO_ID_HI, 4'($urandom)};
      1:       return {AUDIO_ID_HI, 5'($urandom)};
      default: return PRIVATE_ONE;
    endcase
  endfunction

  function automatic logic [15:0] random_length();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] random_hdr_len();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 10));
      1:       return 8'($urandom_range(4, 7));
      default: return 8'($urandom);
    endcase
  endfunction

  // Bias noise toward start code bytes
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'h01;
      default: return 8'($urandom);
    endcase
  endfunction

  // Result sink: stall in random bursts while enabled
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_stall_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Stimulus and verdict
  initial begin
    int         pick;
    int         waited;
    logic [7:0] bad_id;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_data_byte  <= 8'h00;
    src_idle_on   = 1'b0;
    sink_stall_on = 1'b0;
    bytes_sent    = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: video with and without DTS, audio and private ids at their edges
    send_header(8'hE0, 16'h0000, 8'd6, STAMP_MAX, '0);
    send_header(8'hEF, 16'hFFFF, HDR_LEN_LIMIT, '0, STAMP_MAX);
    send_header(8'hC0, 16'h0000, 8'd255, STAMP_MAX, '0);
    send_header(8'hDF, 16'hFFFF, 8'd0, 33'd90000 * 33'd3 + 33'd8, '0);
    send_header(PRIVATE_ONE, 16'h1234, 8'd9, 33'd89999, '0);
    // other stream ids right after a start code must not match
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'hBE);
    send_header(8'hE5, 16'hABCD, 8'd255, 33'd89991, STAMP_MAX);

    // Random: mostly well-formed headers, plus noise, near misses and cut-off headers
    while (bytes_sent < RANDOM_BYTES) begin
      src_idle_on   = bytes_sent < RANDOM_BYTES - QUIET_TAIL && (bytes_sent / 150) % 3 != 1;
      sink_stall_on = bytes_sent < RANDOM_BYTES - QUIET_TAIL && (bytes_sent / 200) % 3 != 2;
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3)) send_byte(noise_byte());
        send_header(random_id(), random_length(), random_hdr_len(), random_stamp(),
                    random_stamp());
      end else if (pick < 16) begin
        repeat ($urandom_range(1, 8)) send_byte(noise_byte());
      end else if (pick < 18) begin
        do bad_id = 8'($urandom);
        while (bad_id[7:4] == VIDEO_ID_HI || bad_id[7:5] == AUDIO_ID_HI ||
               bad_id == PRIVATE_ONE);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(bad_id);
      end else begin
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(random_id());
        repeat ($urandom_range(0, 8)) send_byte(8'($urandom));
      end
    end
    src_idle_on   = 1'b0;
    sink_stall_on = 1'b0;
    in_valid <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    @(posedge clk);
    waited = 0;
    while (headers_due != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);

    if (headers_due != 0)
      $display("[%0t] %0d header results never arrived", $time, headers_due);
    if (error_count == 0 && headers_due == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("[%0t] timeout", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
